/* src/upsd_pkg.sv */
// shared types, character codes and the pair lookup for the percent decoder
`default_nettype none
package upsd_pkg;

    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DIG2    = 8'h32;
    localparam logic [7:0] CH_DIG3    = 8'h33;
    localparam logic [7:0] CH_DIG4    = 8'h34;
    localparam logic [7:0] CH_DIG5    = 8'h35;

    localparam int MAX_RESULTS = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       eot;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                        cnt;
        logic [MAX_RESULTS-1:0][7:0]       bytes;
        logic                              eot;
    } dec_res_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } pair_t;

    // decoded character for percent, hi, lo
    function automatic pair_t decode_pair(input logic [7:0] hi, input logic [7:0] lo);
        pair_t r;
        r.valid = 1'b0;
        r.data  = 8'h00;
        case (hi)
            CH_DIG2: begin
                if (lo >= 8'h30 && lo <= 8'h39) begin
                    r.valid = 1'b1;
                    r.data  = 8'h20 + (lo - 8'h30);
                end else if (lo == 8'h41 || lo == 8'h42 || lo == 8'h43 || lo == 8'h46) begin
                    r.valid = 1'b1;
                    r.data  = 8'h2A + (lo - 8'h41);
                end
            end
            CH_DIG3: begin
                if (lo == 8'h41 || lo == 8'h42 || lo == 8'h44 || lo == 8'h46) begin
                    r.valid = 1'b1;
                    r.data  = 8'h3A + (lo - 8'h41);
                end
            end
            CH_DIG4: begin
                if (lo == 8'h30) begin
                    r.valid = 1'b1;
                    r.data  = 8'h40;
                end
            end
            CH_DIG5: begin
                if (lo == 8'h42 || lo == 8'h44) begin
                    r.valid = 1'b1;
                    r.data  = 8'h5B + (lo - 8'h42);
                end
            end
            default: begin
                r.valid = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* src/upsd_decode.sv */
// sequence state and per-byte decode into up to three result bytes
`default_nettype none
module upsd_decode
    import upsd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire in_item_t item,
    input  wire logic     advance,
    output dec_res_t      res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    always_comb begin
        logic [3:0][7:0] buf_w;
        logic [1:0]      n;
        logic [1:0]      ph;
        pair_t           pr;
        logic            do_plain;
        buf_w      = '0;
        n          = 2'd0;
        ph         = PH_IDLE;
        held_next  = held_reg;
        do_plain   = 1'b0;
        pr         = decode_pair(held_reg, item.data);
        unique case (phase_reg)
            PH_PCT: begin
                if (item.data >= CH_DIG2 && item.data <= CH_DIG5) begin
                    held_next = item.data;
                    ph        = PH_DIGIT;
                end else begin
                    buf_w[n] = CH_PERCENT;
                    n        = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            PH_DIGIT: begin
                if (pr.valid) begin
                    buf_w[n] = pr.data;
                    n        = n + 2'd1;
                end else begin
                    buf_w[n] = CH_PERCENT;
                    n        = n + 2'd1;
                    buf_w[n] = held_reg;
                    n        = n + 2'd1;
                    do_plain = 1'b1;
                end
            end
            default: begin
                do_plain = 1'b1;
            end
        endcase
        if (do_plain) begin
            if (item.data == CH_PERCENT) begin
                ph = PH_PCT;
            end else begin
                buf_w[n] = (item.data == CH_PLUS) ? CH_SPACE : item.data;
                n        = n + 2'd1;
            end
        end
        // end of text flushes whatever is held
        if (item.eot) begin
            if (ph == PH_PCT) begin
                buf_w[n] = CH_PERCENT;
                n        = n + 2'd1;
            end else if (ph == PH_DIGIT) begin
                buf_w[n] = CH_PERCENT;
                n        = n + 2'd1;
                buf_w[n] = held_next;
                n        = n + 2'd1;
            end
            ph = PH_IDLE;
        end
        phase_next = ph;
        res.cnt    = n;
        res.bytes  = buf_w[MAX_RESULTS-1:0];
        res.eot    = item.eot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            held_reg  <= 8'h00;
        end else if (advance) begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule
`default_nettype wire

/* src/upsd_out.sv */
// result buffer that sends the bytes of one input one transfer at a time
`default_nettype none
module upsd_out
    import upsd_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire dec_res_t res,
    input  wire logic     load,
    output logic          can_load,
    output logic          m_tvalid,
    input  wire logic     m_tready,
    output logic [7:0]    m_tdata,   // out_byte
    output logic          m_tlast,   // out_last_of_run
    output logic          m_tuser    // out_end_of_text
);

    logic [MAX_RESULTS-1:0][7:0] buf_reg;
    logic [1:0]                  cnt_reg;
    logic                        eot_reg;
    logic                        xfer;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign xfer     = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (xfer && cnt_reg == 2'd1);
    assign m_tdata  = buf_reg[0];
    assign m_tlast  = (cnt_reg == 2'd1);
    assign m_tuser  = eot_reg && (cnt_reg == 2'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res.cnt;
        end else if (xfer) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            buf_reg <= res.bytes;
            eot_reg <= res.eot;
        end else if (xfer) begin
            buf_reg <= {8'h00, buf_reg[MAX_RESULTS-1:1]};
        end
    end

endmodule
`default_nettype wire

/* src/url_percent_subset_decoder.sv */
// top level of the streaming url percent decoder for the listed codes
//
// channel | dir | tdata          | tlast            | tuser
// s_      | in  | in_byte [7:0]  | in_end_of_text   | -
// m_      | out | out_byte [7:0] | out_last_of_run  | out_end_of_text
//
// one input byte is decoded per cycle between the input register and the result buffer,
// when that buffer can load; an input that yields n result bytes (n is 0 to 3) holds
// the buffer until all are sent, so the input side stalls for each byte beyond the first
// reset clears the held percent sequence and both valid flags
// m_tready low freezes the result buffer, then the input register, then s_tready
`default_nettype none
module url_percent_subset_decoder
    import upsd_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic       s_tlast,   // in_end_of_text
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic            m_tlast,   // out_last_of_run
    output logic            m_tuser    // out_end_of_text
);

    in_item_t in_reg;
    logic     in_valid_reg;
    logic     can_load;
    logic     consume;
    dec_res_t res;

    assign consume  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (consume) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.data <= s_tdata;
            in_reg.eot  <= s_tlast;
        end
    end

    upsd_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (in_reg),
        .advance (consume),
        .res     (res)
    );

    upsd_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res      (res),
        .load     (consume && (res.cnt != 2'd0)),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire
